>>> design/pbpm_pkg.sv
// ---------------------------------------------------------------------------
// pbpm_pkg - shared definitions for the packet buffer pool manager
// Operation codes, register indexes, field widths and the command groups
// that the control logic sends to the ID stacks and the ready FIFO.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbpm_pkg;

  // Fixed field widths
  localparam int ID_W      = 6;   // buffer ID
  localparam int OP_W      = 3;   // operation selector
  localparam int BASE_W    = 5;   // base_buffers register
  localparam int MAXSZ_W   = 16;  // max_packet_size register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = MAXSZ_W;

  // Parameter defaults
  localparam int DEF_MAX_BASE_BUFFERS = 16;
  localparam int DEF_SURGE_FACTOR     = 3;
  localparam int DEF_SIZE_BITS        = 16;

  // Register reset values
  localparam int RST_BASE_BUFFERS = 16;
  localparam logic [MAXSZ_W-1:0] RST_MAX_PACKET_SIZE = 16'd4096;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESERVE   = 3'd0;
  localparam logic [OP_W-1:0] OP_COMMIT    = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE   = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_READ = 3'd3;
  localparam logic [OP_W-1:0] OP_GET_READY = 3'd4;
  localparam logic [OP_W-1:0] OP_REINIT    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BUFFERS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSUMER_ATT  = 2'd2;

  // Stack command group
  typedef struct packed {
    logic push;
    logic pop;
    logic rebuild;
  } stk_cmd_t;

  // FIFO command group
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_cmd_t;

endpackage

`default_nettype wire

>>> design/packet_buffer_pool_manager_core.sv
// ---------------------------------------------------------------------------
// packet_buffer_pool_manager_core - buffer pool with free stack, surge IDs
// and a ready FIFO
// Reserve pops the free stack or creates a surge buffer from the spare-ID
// stack; commit queues ID and size; release/mark_read return IDs; reinit
// rebuilds all stores.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  in_     | in  | in_tvalid/tready   | tuser op; tdata size,id,notify
//  out_    | out | out_tvalid/tready  | tdata ok,id,size,ready_to_read
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
//  Each request is accepted in ST_IDLE, then handled in ST_EXEC, in which the
//  registered memory reads return and the stacks/FIFO are written back.
//  The memories are read every cycle at the current top/head address.
//  A held output register stalls the execute cycle; in_tready stays high
//  while idle even if a result is still waiting.
//  Reset is synchronous (rst_n low); no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packet_buffer_pool_manager_core #(
  parameter int MAX_BASE_BUFFERS = pbpm_pkg::DEF_MAX_BASE_BUFFERS,
  parameter int SURGE_FACTOR     = pbpm_pkg::DEF_SURGE_FACTOR,
  parameter int SIZE_BITS        = pbpm_pkg::DEF_SIZE_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // size, buffer_id, notify
  input  wire logic [((SIZE_BITS+pbpm_pkg::ID_W+8)/8)*8-1:0] in_tdata,
  // operation
  input  wire logic [pbpm_pkg::OP_W-1:0]          in_tuser,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // ok, granted_id, granted_size, ready_to_read
  output logic [((SIZE_BITS+pbpm_pkg::ID_W+9)/8)*8-1:0] out_tdata,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pbpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pbpm_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import pbpm_pkg::*;

  localparam int FREE_DEPTH  = MAX_BASE_BUFFERS + 1;
  localparam int SPARE_DEPTH = MAX_BASE_BUFFERS * SURGE_FACTOR;
  localparam int FIFO_DEPTH  = MAX_BASE_BUFFERS * SURGE_FACTOR;
  localparam int FC_W        = $clog2(FREE_DEPTH + 1);
  localparam int SC_W        = $clog2(SPARE_DEPTH + 1);
  localparam int QC_W        = $clog2(FIFO_DEPTH + 1);
  localparam int CW_RAW      = $clog2(FREE_DEPTH + SPARE_DEPTH + 1);
  localparam int CW          = (CW_RAW > ID_W) ? CW_RAW : ID_W;
  localparam int CMP_W       = (SIZE_BITS > MAXSZ_W) ? SIZE_BITS : MAXSZ_W;
  localparam int ENTRY_W     = ID_W + SIZE_BITS;
  localparam int OUT_W       = ((SIZE_BITS + ID_W + 9) / 8) * 8;
  localparam int RST_EFF     = (RST_BASE_BUFFERS > MAX_BASE_BUFFERS) ?
                               MAX_BASE_BUFFERS : RST_BASE_BUFFERS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [BASE_W-1:0]  base_r;
  logic [MAXSZ_W-1:0] max_size_r;
  logic               consumer_r;

  // Latched request
  logic [OP_W-1:0]      op_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [ID_W-1:0]      id_r;
  logic                 notify_r;

  logic [CW-1:0] live_r, live_nxt;

  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  // Store interfaces
  stk_cmd_t  free_cmd, free_cmd_raw;
  stk_cmd_t  spare_cmd, spare_cmd_raw;
  fifo_cmd_t fifo_cmd, fifo_cmd_raw;
  logic [FC_W-1:0]    free_count;
  logic [SC_W-1:0]    spare_count;
  logic [QC_W-1:0]    fifo_count;
  logic [ID_W-1:0]    free_top, spare_top;
  logic [ENTRY_W-1:0] fifo_rd, fifo_wr;

  logic [CW-1:0] eff_base, surge_lim, spare_rebuild;
  logic [CW-1:0] free_cnt_x, spare_cnt_x, fifo_cnt_x;
  logic          in_fire, exec_fire;
  logic          ok;
  logic [ID_W-1:0]      gid;
  logic [SIZE_BITS-1:0] gsize;
  logic                 rtr;
  logic [OUT_W-1:0]     out_word;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= BASE_W'(RST_BASE_BUFFERS);
      max_size_r <= RST_MAX_PACKET_SIZE;
      consumer_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_BUFFERS: base_r     <= cfg_data[BASE_W-1:0];
        CFG_MAX_PKT_SIZE: max_size_r <= cfg_data[MAXSZ_W-1:0];
        CFG_CONSUMER_ATT: consumer_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_tuser;
      size_r   <= in_tdata[SIZE_BITS-1:0];
      id_r     <= in_tdata[SIZE_BITS +: ID_W];
      notify_r <= in_tdata[SIZE_BITS+ID_W];
    end
  end

  // Effective base and surge limit
  always_comb begin
    if (base_r == '0) begin
      eff_base = CW'(1);
    end else if (CW'(base_r) > CW'(MAX_BASE_BUFFERS)) begin
      eff_base = CW'(MAX_BASE_BUFFERS);
    end else begin
      eff_base = CW'(base_r);
    end
  end

  assign surge_lim     = CW'(eff_base * CW'(SURGE_FACTOR));
  assign spare_rebuild = CW'(eff_base * CW'(SURGE_FACTOR - 1));
  assign free_cnt_x    = CW'(free_count);
  assign spare_cnt_x   = CW'(spare_count);
  assign fifo_cnt_x    = CW'(fifo_count);
  assign fifo_wr       = {size_r, id_r};

  // Operation decode and result
  always_comb begin
    free_cmd_raw  = '0;
    spare_cmd_raw = '0;
    fifo_cmd_raw  = '0;
    live_nxt      = live_r;
    ok            = 1'b0;
    gid           = '0;
    gsize         = '0;
    rtr           = 1'b0;
    case (op_r)
      OP_RESERVE: begin
        if (CMP_W'(size_r) <= CMP_W'(max_size_r)) begin
          if (free_cnt_x != '0) begin
            free_cmd_raw.pop = 1'b1;
            gid              = free_top;
            ok               = 1'b1;
          end else if (live_r < surge_lim && spare_cnt_x != '0) begin
            spare_cmd_raw.pop = 1'b1;
            gid               = spare_top;
            live_nxt          = CW'(live_r + CW'(1));
            ok                = 1'b1;
          end
          if (ok) begin
            gsize = size_r;
          end
        end
      end
      OP_COMMIT: begin
        if (fifo_cnt_x < CW'(FIFO_DEPTH)) begin
          fifo_cmd_raw.push = 1'b1;
        end
        rtr = notify_r & consumer_r;
      end
      OP_RELEASE, OP_MARK_READ: begin
        if (free_cnt_x <= eff_base && free_cnt_x < CW'(FREE_DEPTH)) begin
          free_cmd_raw.push = 1'b1;
        end else begin
          // destroy: ID back to the spare stack
          if (spare_cnt_x < CW'(SPARE_DEPTH)) begin
            spare_cmd_raw.push = 1'b1;
          end
          if (live_r > eff_base) begin
            live_nxt = CW'(live_r - CW'(1));
          end
        end
      end
      OP_GET_READY: begin
        if (fifo_cnt_x != '0) begin
          fifo_cmd_raw.pop = 1'b1;
          gid              = fifo_rd[ID_W-1:0];
          gsize            = fifo_rd[ID_W +: SIZE_BITS];
          ok               = 1'b1;
        end
      end
      OP_REINIT: begin
        free_cmd_raw.rebuild  = 1'b1;
        spare_cmd_raw.rebuild = 1'b1;
        fifo_cmd_raw.clear    = 1'b1;
        live_nxt              = eff_base;
      end
      default: ;
    endcase
  end

  assign free_cmd  = exec_fire ? free_cmd_raw  : '0;
  assign spare_cmd = exec_fire ? spare_cmd_raw : '0;
  assign fifo_cmd  = exec_fire ? fifo_cmd_raw  : '0;

  // Result word packing
  always_comb begin
    out_word                        = '0;
    out_word[0]                     = ok;
    out_word[ID_W:1]                = gid;
    out_word[ID_W+1 +: SIZE_BITS]   = gsize;
    out_word[ID_W+SIZE_BITS+1]      = rtr;
  end

  // FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire)   state_nxt = ST_EXEC;
      ST_EXEC: if (exec_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= CW'(RST_EFF);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        live_r <= live_nxt;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= out_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Stores
  pbpm_id_stack #(
    .DEPTH     (FREE_DEPTH),
    .RST_COUNT (RST_EFF),
    .RST_BASE  (0)
  ) u_free_stack (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (free_cmd),
    .push_id       (id_r),
    .rebuild_count (FC_W'(eff_base)),
    .rebuild_base  ('0),
    .count         (free_count),
    .top_id        (free_top)
  );

  pbpm_id_stack #(
    .DEPTH     (SPARE_DEPTH),
    .RST_COUNT ((SURGE_FACTOR - 1) * RST_EFF),
    .RST_BASE  (RST_EFF)
  ) u_spare_stack (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (spare_cmd),
    .push_id       (id_r),
    .rebuild_count (SC_W'(spare_rebuild)),
    .rebuild_base  (eff_base[ID_W-1:0]),
    .count         (spare_count),
    .top_id        (spare_top)
  );

  pbpm_ready_fifo #(
    .DEPTH  (FIFO_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_ready_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (fifo_cmd),
    .wr_data (fifo_wr),
    .count   (fifo_count),
    .rd_data (fifo_rd)
  );

endmodule

`default_nettype wire

>>> design/pbpm_id_stack.sv
// ---------------------------------------------------------------------------
// pbpm_id_stack - LIFO of buffer IDs in a synchronous memory
// Top entry is read every cycle into a register. A low-water mark tracks the
// lowest slot written since the last rebuild; slots below it still hold
// their rebuild value (slot index plus a base), so a rebuild does not rewrite the memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbpm_id_stack #(
  parameter int DEPTH     = 17,
  parameter int RST_COUNT = 16,
  parameter int RST_BASE  = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pbpm_pkg::stk_cmd_t             cmd,
  input  wire logic [pbpm_pkg::ID_W-1:0]      push_id,
  input  wire logic [$clog2(DEPTH+1)-1:0]     rebuild_count,
  input  wire logic [pbpm_pkg::ID_W-1:0]      rebuild_base,
  output logic      [$clog2(DEPTH+1)-1:0]     count,
  output logic      [pbpm_pkg::ID_W-1:0]      top_id
);
  import pbpm_pkg::*;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ID_W-1:0]   mem [DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  lwm_r, lwm_nxt;
  logic [ID_W-1:0]   base_r, base_nxt;
  logic [ID_W-1:0]   rd_data_r;
  logic              rd_dflt_r;
  logic [ID_W-1:0]   rd_dflt_id_r;
  logic [CNT_W-1:0]  top_idx;

  assign top_idx = CNT_W'(count_r - CNT_W'(1));

  // Top-of-stack read, registered
  always_ff @(posedge clk) begin
    rd_data_r    <= mem[top_idx[ADDR_W-1:0]];
    rd_dflt_r    <= (top_idx < lwm_r);
    rd_dflt_id_r <= ID_W'(base_r + ID_W'(top_idx));
  end

  // Push writes the slot at the current count
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count_r[ADDR_W-1:0]] <= push_id;
    end
  end

  // Count, low-water mark and rebuild base
  always_comb begin
    count_nxt = count_r;
    lwm_nxt   = lwm_r;
    base_nxt  = base_r;
    if (cmd.rebuild) begin
      count_nxt = rebuild_count;
      lwm_nxt   = CNT_W'(DEPTH);
      base_nxt  = rebuild_base;
    end else if (cmd.push) begin
      count_nxt = CNT_W'(count_r + CNT_W'(1));
      lwm_nxt   = (count_r < lwm_r) ? count_r : lwm_r;
    end else if (cmd.pop) begin
      count_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(RST_COUNT);
      lwm_r   <= CNT_W'(DEPTH);
      base_r  <= ID_W'(RST_BASE);
    end else begin
      count_r <= count_nxt;
      lwm_r   <= lwm_nxt;
      base_r  <= base_nxt;
    end
  end

  assign count  = count_r;
  assign top_id = rd_dflt_r ? rd_dflt_id_r : rd_data_r;

endmodule

`default_nettype wire

>>> design/pbpm_ready_fifo.sv
// ---------------------------------------------------------------------------
// pbpm_ready_fifo - circular FIFO of committed buffers (ID and size)
// Head entry is read every cycle into a register; head and tail wrap at
// any depth.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbpm_ready_fifo #(
  parameter int DEPTH  = 48,
  parameter int DATA_W = 22
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pbpm_pkg::fifo_cmd_t        cmd,
  input  wire logic [DATA_W-1:0]          wr_data,
  output logic      [$clog2(DEPTH+1)-1:0] count,
  output logic      [DATA_W-1:0]          rd_data
);
  import pbpm_pkg::*;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] rd_data_r;

  // Head read, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= wr_data;
    end
  end

  // Pointer update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push) begin
      tail_nxt  = (tail_r == LAST) ? '0 : ADDR_W'(tail_r + ADDR_W'(1));
      count_nxt = CNT_W'(count_r + CNT_W'(1));
    end else if (cmd.pop) begin
      head_nxt  = (head_r == LAST) ? '0 : ADDR_W'(head_r + ADDR_W'(1));
      count_nxt = CNT_W'(count_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign count   = count_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> design/pbpm_checker.sv
// ---------------------------------------------------------------------------
// pbpm_checker - port-level checks for the pool manager
// Request/result timing and result field consistency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbpm_checker #(
  parameter int SIZE_BITS = pbpm_pkg::DEF_SIZE_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [((SIZE_BITS+pbpm_pkg::ID_W+9)/8)*8-1:0] out_tdata
);
  import pbpm_pkg::*;

  localparam int RTR_BIT = ID_W + SIZE_BITS + 1;

  // One request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one still executing");

  // A rising result valid traces back to an accepted request, with the execute state between them
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a matching request");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // Failed or non-granting request carries zero id and size, and a grant
  // never comes with a ready pulse
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[0] || out_tdata[RTR_BIT-1:1] == '0) &&
                    !(out_tdata[0] && out_tdata[RTR_BIT])))
    else $error("inconsistent result fields");

endmodule

bind packet_buffer_pool_manager_core pbpm_checker #(
  .SIZE_BITS (SIZE_BITS)
) u_pbpm_checker (.*);

`default_nettype wire

>>> tb/packet_buffer_pool_manager_core_test.sv
// ---------------------------------------------------------------------------
// packet_buffer_pool_manager_core_test - self-checking bench for the pool core
// Streams reserve/commit/release/mark_read/get_readable/reinit requests into
// the core under random bursts, gaps and result-side stalls. A local model of
// the free stack, spare-ID stack, ready FIFO and live count computes the
// grant owed for every accepted request; each result is checked field by
// field. Runs through several register settings, written only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_buffer_pool_manager_core_test;
  import pbpm_pkg::*;

  localparam int SZ_W        = DEF_SIZE_BITS;
  localparam int MAX_BASE    = DEF_MAX_BASE_BUFFERS;
  localparam int SURGE       = DEF_SURGE_FACTOR;
  localparam int FREE_DEPTH  = MAX_BASE + 1;
  localparam int SPARE_DEPTH = MAX_BASE * SURGE;
  localparam int FIFO_DEPTH  = MAX_BASE * SURGE;
  localparam int IN_W        = ((SZ_W + ID_W + 8) / 8) * 8;
  localparam int OUT_W       = ((SZ_W + ID_W + 9) / 8) * 8;
  localparam int QUIET_LIMIT = 5000;

  // op codes the core does not define; it must answer them with all zeros
  localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [SZ_W-1:0] size;
    logic [ID_W-1:0] id;
    logic            notify;
    bit              drain_first;   // hold until every grant is back
  } pool_req_t;

  // laid out as out_tdata, lowest bit last
  typedef struct packed {
    logic            ready_to_read;
    logic [SZ_W-1:0] granted_size;
    logic [ID_W-1:0] granted_id;
    logic            ok;
  } pool_grant_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [SZ_W-1:0] size;
  } rd_entry_t;

  typedef enum int {SC_LIFECYCLE, SC_EXHAUST, SC_FIFO_FILL, SC_FLOOD, SC_NOISE} scen_t;
  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_BURSTS} rdy_mode_t;

  // DUT ports
  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;   // size, buffer_id, notify, pad
  logic [OP_W-1:0]      in_tuser   = '0;   // operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;         // ok, granted_id, granted_size, ready_to_read
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  // model copy of the registers
  logic [BASE_W-1:0]  pool_base_reg;
  logic [MAXSZ_W-1:0] max_size_reg;
  logic               consumer_reg;

  // model copy of the pool
  logic [ID_W-1:0] free_ids [FREE_DEPTH];
  logic [4:0]      free_n;
  logic [ID_W-1:0] spare_ids [SPARE_DEPTH];
  logic [5:0]      spare_n;
  rd_entry_t       rd_fifo [FIFO_DEPTH];
  logic [5:0]      rd_head, rd_tail, rd_n;
  logic [5:0]      live_n;

  pool_req_t   op_queue[$];
  pool_grant_t due_grants[$];
  pool_req_t   cur_req;
  int          reqs_queued  = 0;
  int          reqs_taken   = 0;
  int          mismatch_cnt = 0;
  bit          next_drain   = 1'b0;

  packet_buffer_pool_manager_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // base register clamped to 1..MAX_BASE
  function automatic logic [BASE_W-1:0] pool_base();
    if (pool_base_reg == '0) return BASE_W'(1);
    if (pool_base_reg > BASE_W'(MAX_BASE)) return BASE_W'(MAX_BASE);
    return pool_base_reg;
  endfunction

  function automatic void rebuild_pool();
    logic [BASE_W-1:0] b;
    int i;
    b = pool_base();
    free_n = '0;
    for (i = 0; i < b; i++) begin
      free_ids[free_n] = ID_W'(i);
      free_n++;
    end
    spare_n = '0;
    for (i = b; i < b * SURGE && spare_n < SPARE_DEPTH; i++) begin
      spare_ids[spare_n] = ID_W'(i);
      spare_n++;
    end
    rd_head = '0;
    rd_tail = '0;
    rd_n    = '0;
    live_n  = 6'(b);
  endfunction

  // back to the free stack, or destroyed once that stack is over base
  function automatic void return_id(logic [ID_W-1:0] id);
    logic [BASE_W-1:0] b;
    b = pool_base();
    if (free_n <= b && free_n < FREE_DEPTH) begin
      free_ids[free_n] = id;
      free_n++;
    end else begin
      if (spare_n < SPARE_DEPTH) begin
        spare_ids[spare_n] = id;
        spare_n++;
      end
      if (live_n > b) live_n--;
    end
  endfunction

  // applies one request to the model pool and queues the grant it owes
  function automatic void apply_pool_op(pool_req_t req);
    pool_grant_t g;
    logic [6:0]  cap;
    g = '0;
    case (req.op)
      OP_RESERVE: begin
        if (req.size <= max_size_reg) begin
          cap = 7'(pool_base()) * 7'(SURGE);
          if (free_n > 0) begin
            free_n--;
            g.granted_id = free_ids[free_n];
            g.ok = 1'b1;
          end else if (live_n < cap && spare_n > 0) begin
            // surge buffer
            spare_n--;
            g.granted_id = spare_ids[spare_n];
            live_n++;
            g.ok = 1'b1;
          end
          if (g.ok) g.granted_size = req.size;
        end
      end
      OP_COMMIT: begin
        // full FIFO drops the entry, the pulse still follows notify and consumer
        if (rd_n < FIFO_DEPTH) begin
          rd_fifo[rd_tail].id   = req.id;
          rd_fifo[rd_tail].size = req.size;
          rd_tail = (rd_tail == FIFO_DEPTH - 1) ? '0 : rd_tail + 6'd1;
          rd_n++;
        end
        g.ready_to_read = req.notify & consumer_reg;
      end
      OP_RELEASE, OP_MARK_READ: return_id(req.id);
      OP_GET_READY: begin
        if (rd_n > 0) begin
          g.granted_id   = rd_fifo[rd_head].id;
          g.granted_size = rd_fifo[rd_head].size;
          rd_head = (rd_head == FIFO_DEPTH - 1) ? '0 : rd_head + 6'd1;
          rd_n--;
          g.ok = 1'b1;
        end
      end
      OP_REINIT: rebuild_pool();
      default: ;
    endcase
    due_grants.insert(due_grants.size(), g);
  endfunction

  task automatic flag_mismatch(string what, int unsigned got_v, int unsigned want_v);
    $display("ERROR %0t: %s got 0x%0h want 0x%0h", $time, what, got_v, want_v);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------- driver

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : req_driver
    logic take;
    take = in_tvalid && in_tready;
    if (take) begin
      apply_pool_op(cur_req);
      reqs_taken++;
    end
    if (in_tvalid && !take) begin
      // request still waiting, hold it
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (op_queue.size() > 0 &&
                 !(op_queue[0].drain_first && due_grants.size() > 0)) begin
      cur_req = op_queue.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= cur_req.op;
      in_tdata  <= {1'b0, cur_req.notify, cur_req.id, cur_req.size};
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor

  rdy_mode_t rdy_mode  = RDY_ALWAYS;
  int        mode_left = 0;
  int        stall_left = 0;

  always @(posedge clk) begin : grant_monitor
    pool_grant_t got, want;
    logic        next_ready;
    if (rst_n && out_tvalid && out_tready) begin
      got = pool_grant_t'(out_tdata);
      if (due_grants.size() == 0) begin
        flag_mismatch("result with no request due", int'(got), 0);
      end else begin
        want = due_grants.pop_front();
        if (got.ok !== want.ok) flag_mismatch("ok", got.ok, want.ok);
        if (got.granted_id !== want.granted_id)
          flag_mismatch("granted_id", got.granted_id, want.granted_id);
        if (got.granted_size !== want.granted_size)
          flag_mismatch("granted_size", got.granted_size, want.granted_size);
        if (got.ready_to_read !== want.ready_to_read)
          flag_mismatch("ready_to_read", got.ready_to_read, want.ready_to_read);
      end
    end
    // result-side stall pattern, mode changes at random intervals
    if (mode_left == 0) begin
      rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    case (rdy_mode)
      RDY_ALWAYS: next_ready = 1'b1;
      RDY_HALF:   next_ready = 1'($urandom_range(0, 1));
      RDY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          next_ready = 1'b0;
        end else begin
          next_ready = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
        end
      end
    endcase
    out_tready <= next_ready;
  end

  // ---------------------------------------------------------------- watchdog

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_req(logic [OP_W-1:0] op, logic [SZ_W-1:0] size,
                           logic [ID_W-1:0] id, logic notify);
    pool_req_t r;
    r.op = op;
    r.size = size;
    r.id = id;
    r.notify = notify;
    r.drain_first = next_drain;
    next_drain = 1'b0;
    op_queue.insert(op_queue.size(), r);
    reqs_queued++;
  endtask

  // mostly within the size limit, with the edges around it
  function automatic logic [SZ_W-1:0] req_size();
    case ($urandom_range(0, 9))
      0: return SZ_W'($urandom);
      1: return max_size_reg;
      2: return max_size_reg + 16'd1;
      3: return '0;
      default: return SZ_W'($urandom_range(0, max_size_reg));
    endcase
  endfunction

  // an ID the pool could have handed out, sometimes a foreign one
  function automatic logic [ID_W-1:0] pool_id();
    if ($urandom_range(0, 9) == 0) return ID_W'($urandom_range(48, 63));
    return ID_W'($urandom_range(0, pool_base() * SURGE - 1));
  endfunction

  function automatic logic [OP_W-1:0] give_op();
    return $urandom_range(0, 1) ? OP_RELEASE : OP_MARK_READ;
  endfunction

  task automatic add_scenario(scen_t kind);
    int n, i;
    next_drain = ($urandom_range(0, 7) == 0);
    case (kind)
      SC_LIFECYCLE: begin
        n = $urandom_range(1, 20);
        if ($urandom_range(0, 9) == 0)
          queue_req(OP_REINIT, SZ_W'($urandom), ID_W'($urandom), 1'($urandom));
        if ($urandom_range(0, 1)) begin
          // one buffer at a time through its whole life
          for (i = 0; i < n; i++) begin
            queue_req(OP_RESERVE, req_size(), ID_W'($urandom), 1'($urandom));
            queue_req(OP_COMMIT, SZ_W'($urandom), pool_id(), 1'($urandom));
            queue_req(OP_GET_READY, SZ_W'($urandom), ID_W'($urandom), 1'($urandom));
            queue_req(give_op(), SZ_W'($urandom), pool_id(), 1'($urandom));
          end
        end else begin
          // each stage for the whole group
          for (i = 0; i < n; i++)
            queue_req(OP_RESERVE, req_size(), ID_W'($urandom), 1'($urandom));
          for (i = 0; i < n; i++)
            queue_req(OP_COMMIT, SZ_W'($urandom), pool_id(), 1'($urandom));
          for (i = 0; i <= n; i++)
            queue_req(OP_GET_READY, SZ_W'($urandom), ID_W'($urandom), 1'($urandom));
          for (i = 0; i < n; i++)
            queue_req(give_op(), SZ_W'($urandom), pool_id(), 1'($urandom));
        end
      end
      SC_EXHAUST: begin
        // run past the free stack into surge buffers and past the surge cap
        n = $urandom_range(20, 55);
        for (i = 0; i < n; i++)
          queue_req(OP_RESERVE, req_size(), ID_W'($urandom), 1'($urandom));
        n = $urandom_range(20, 55);
        for (i = 0; i < n; i++)
          queue_req(give_op(), SZ_W'($urandom), pool_id(), 1'($urandom));
      end
      SC_FIFO_FILL: begin
        n = $urandom_range(45, 55);
        for (i = 0; i < n; i++)
          queue_req(OP_COMMIT, SZ_W'($urandom), pool_id(), 1'($urandom));
        n = $urandom_range(45, 55);
        for (i = 0; i < n; i++)
          queue_req(OP_GET_READY, SZ_W'($urandom), ID_W'($urandom), 1'($urandom));
      end
      SC_FLOOD: begin
        // overfill the free stack so buffers get destroyed
        n = $urandom_range(30, 60);
        for (i = 0; i < n; i++)
          queue_req(give_op(), SZ_W'($urandom), pool_id(), 1'($urandom));
      end
      default: begin
        n = $urandom_range(5, 20);
        for (i = 0; i < n; i++)
          queue_req(OP_W'($urandom_range(0, 7)),
                    $urandom_range(0, 1) ? req_size() : SZ_W'($urandom),
                    ID_W'($urandom), 1'($urandom));
      end
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (reqs_taken != reqs_queued || due_grants.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE_BUFFERS: pool_base_reg = data[BASE_W-1:0];
      CFG_MAX_PKT_SIZE: max_size_reg  = data[MAXSZ_W-1:0];
      CFG_CONSUMER_ATT: consumer_reg  = data[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(int target, scen_t lead);
    int goal;
    int r;
    goal = reqs_queued + target;
    add_scenario(lead);
    while (reqs_queued < goal) begin
      r = $urandom_range(0, 19);
      if (r < 8)       add_scenario(SC_LIFECYCLE);
      else if (r < 11) add_scenario(SC_EXHAUST);
      else if (r < 13) add_scenario(SC_FIFO_FILL);
      else if (r < 15) add_scenario(SC_FLOOD);
      else             add_scenario(SC_NOISE);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    pool_base_reg = BASE_W'(RST_BASE_BUFFERS);
    max_size_reg  = RST_MAX_PACKET_SIZE;
    consumer_reg  = 1'b0;
    rebuild_pool();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, edges of every field and operation
    queue_req(OP_GET_READY, '0, '0, 1'b0);                  // empty FIFO
    queue_req(OP_RESERVE, 16'd4096, 6'h3F, 1'b1);           // exactly max
    queue_req(OP_RESERVE, 16'd4097, '0, 1'b0);              // one over max
    queue_req(OP_RESERVE, '0, '0, 1'b0);
    queue_req(OP_RESERVE, 16'hFFFF, '0, 1'b1);
    queue_req(OP_COMMIT, 16'hFFFF, 6'h3F, 1'b1);            // foreign ID, no consumer
    queue_req(OP_COMMIT, '0, 6'd1, 1'b0);
    next_drain = 1'b1;
    queue_req(OP_GET_READY, '0, '0, 1'b0);
    queue_req(OP_GET_READY, 16'hFFFF, 6'h3F, 1'b1);
    queue_req(OP_GET_READY, '0, '0, 1'b0);
    queue_req(OP_RELEASE, '0, 6'd1, 1'b0);
    queue_req(OP_MARK_READ, '0, 6'd0, 1'b0);
    queue_req(OP_RELEASE, 16'hAAAA, 6'd47, 1'b1);           // free stack over base
    queue_req(OP_MARK_READ, 16'h5555, 6'd48, 1'b0);         // destroyed
    queue_req(OP_UNDEF_A, '0, '0, 1'b0);
    queue_req(OP_UNDEF_B, 16'hFFFF, 6'h3F, 1'b1);
    queue_req(OP_REINIT, 16'hFFFF, 6'h3F, 1'b1);
    queue_req(OP_RESERVE, 16'd1, '0, 1'b0);
    wait_idle();

    // smallest pool, no size limit, consumer attached
    write_reg(CFG_CONSUMER_ATT, {15'($urandom), 1'b1});
    write_reg(CFG_BASE_BUFFERS, {11'($urandom), 5'd1});
    write_reg(CFG_MAX_PKT_SIZE, 16'hFFFF);
    queue_req(OP_REINIT, '0, '0, 1'b0);
    run_phase(220, SC_EXHAUST);

    // base of zero acts as one; only size zero may be reserved
    write_reg(CFG_BASE_BUFFERS, {11'($urandom), 5'd0});
    write_reg(CFG_MAX_PKT_SIZE, 16'h0000);
    write_reg(CFG_CONSUMER_ATT, {15'($urandom), 1'b0});
    run_phase(130, SC_LIFECYCLE);

    // base above the maximum, stores left from the small pool
    write_reg(CFG_BASE_BUFFERS, {11'($urandom), 5'd31});
    write_reg(CFG_MAX_PKT_SIZE, 16'd4096);
    write_reg(CFG_CONSUMER_ATT, {15'($urandom), 1'b1});
    run_phase(260, SC_EXHAUST);

    write_reg(CFG_BASE_BUFFERS, {11'($urandom), 5'd5});
    write_reg(CFG_MAX_PKT_SIZE, 16'($urandom_range(100, 60000)));
    write_reg(CFG_CONSUMER_ATT, 16'($urandom));
    queue_req(OP_REINIT, '0, '0, 1'b0);
    run_phase(260, SC_FLOOD);

    write_reg(CFG_BASE_BUFFERS, {11'($urandom), 5'd16});
    write_reg(CFG_MAX_PKT_SIZE, 16'd1500);
    write_reg(CFG_CONSUMER_ATT, {15'($urandom), 1'b1});
    queue_req(OP_REINIT, '0, '0, 1'b0);
    run_phase(310, SC_FIFO_FILL);

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/pbpm_pkg.sv
design/pbpm_id_stack.sv
design/pbpm_ready_fifo.sv
design/packet_buffer_pool_manager_core.sv
design/pbpm_checker.sv
tb/packet_buffer_pool_manager_core_test.sv
